// ===== rtl/iou_greedy_box_tracker_assert.svh =====
// Assertion macros used by the greedy IoU box tracker datapath.
`ifndef IOU_GREEDY_BOX_TRACKER_ASSERT_SVH
`define IOU_GREEDY_BOX_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define IGBT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("igbt assertion failed");

// Next-cycle implication.
`define IGBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("igbt assertion failed");

`endif

// ===== rtl/igbt_pkg.sv =====
// Package: types, codes and constants of the greedy IoU box tracker.
`default_nettype none
package igbt_pkg;

   localparam int DEF_MAX_DETECTIONS = 32;
   localparam int DEF_MAX_TRACKS     = 32;
   localparam int DEF_COORD_BITS     = 12;

   localparam int SCORE_W    = 16;
   localparam int LEN_W      = 10;
   localparam int ID_W       = 32;
   localparam int KIND_W     = 2;
   localparam int CMD_W      = 2;
   localparam int DROP_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [LEN_W-1:0]   LEN_MAX        = 10'd1023;
   localparam logic [SCORE_W-1:0] SCORE_HIGH_RST = 16'd32768;
   localparam logic [SCORE_W-1:0] IOU_MIN_RST    = 16'd32768;
   localparam logic [LEN_W-1:0]   MIN_LENGTH_RST = 10'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD      = 2'd0,
      CMD_END_FRAME = 2'd1,
      CMD_FLUSH     = 2'd2,
      CMD_NONE      = 2'd3
   } command_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TRACK      = 2'd0,
      KIND_FRAME_DONE = 2'd1,
      KIND_FLUSH_DONE = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCORE_HIGH = 2'd0,
      CSR_IOU_MIN    = 2'd1,
      CSR_MIN_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_T_RD,
      S_T_LAT,
      S_D_RD,
      S_D_GEO,
      S_D_MUL,
      S_D_UNI,
      S_D_CROSS,
      S_D_CMP,
      S_T_DEC,
      S_T_ACT,
      S_B_RD,
      S_B_WR,
      S_T_EMIT,
      S_T_NEXT,
      S_N_RD,
      S_N_WR,
      S_F_DONE,
      S_L_RD,
      S_L_LAT,
      S_L_CHK,
      S_L_DONE
   } state_type;

   typedef struct packed {
      logic     load;
      logic     start_frame;
      logic     clr_t;
      logic     inc_t;
      logic     clr_d;
      logic     inc_d;
      logic     latch_trk;
      logic     best_rd;
      logic     cmp_en;
      logic     match_wr;
      logic     new_wr;
      logic     emit_rec;
      logic     emit_done;
      kind_type done_kind;
      logic     frame_end;
   } ctrl_cmd_type;

   typedef struct packed {
      logic trk_empty;
      logic det_empty;
      logic t_last;
      logic d_last;
      logic out_free;
      logic match_ok;
      logic rec_ok;
      logic flush_ok;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/iou_greedy_box_tracker.sv =====
// Top level of the greedy IoU box tracker: controller, datapath and CSR port.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  command, box, confidence
//   rsp_      out        rsp_valid/rsp_stall  one result row per transfer
//   csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// Load and ignored commands are taken back to back; the controller stays idle.
// End of frame: each of the T active tracks is matched against the D loaded
// detections through the shared IoU unit; result stalls can hold the pass.
// Flush: each active track is read, checked and, if it qualifies, emitted in turn; result stalls can hold it.
// Synchronous reset; no clearing pass. req_stall is high outside idle.
`default_nettype none
module iou_greedy_box_tracker #(
   parameter int MAX_DETECTIONS = igbt_pkg::DEF_MAX_DETECTIONS,
   parameter int MAX_TRACKS     = igbt_pkg::DEF_MAX_TRACKS,
   parameter int COORD_BITS     = igbt_pkg::DEF_COORD_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [igbt_pkg::CMD_W-1:0]        req_command,
   input  wire logic [COORD_BITS-1:0]             req_box_left,
   input  wire logic [COORD_BITS-1:0]             req_box_top,
   input  wire logic [COORD_BITS-1:0]             req_box_right,
   input  wire logic [COORD_BITS-1:0]             req_box_bottom,
   input  wire logic [igbt_pkg::SCORE_W-1:0]      req_confidence,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [igbt_pkg::KIND_W-1:0]            rsp_kind,
   output logic [igbt_pkg::ID_W-1:0]              rsp_track_number,
   output logic [igbt_pkg::ID_W-1:0]              rsp_first_frame,
   output logic [igbt_pkg::LEN_W-1:0]             rsp_track_length,
   output logic [igbt_pkg::SCORE_W-1:0]           rsp_best_score,
   output logic [COORD_BITS-1:0]                  rsp_last_left,
   output logic [COORD_BITS-1:0]                  rsp_last_top,
   output logic [COORD_BITS-1:0]                  rsp_last_right,
   output logic [COORD_BITS-1:0]                  rsp_last_bottom,
   output logic [igbt_pkg::DROP_W-1:0]            rsp_dropped,
   output logic                                   rsp_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [igbt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [igbt_pkg::CSR_DATA_W-1:0]   csr_data
);
   import igbt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   igbt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   igbt_dp #(
      .MAX_DETECTIONS (MAX_DETECTIONS),
      .MAX_TRACKS     (MAX_TRACKS),
      .COORD_BITS     (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_box_left     (req_box_left),
      .req_box_top      (req_box_top),
      .req_box_right    (req_box_right),
      .req_box_bottom   (req_box_bottom),
      .req_confidence   (req_confidence),
      .csr_wr           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_track_number (rsp_track_number),
      .rsp_first_frame  (rsp_first_frame),
      .rsp_track_length (rsp_track_length),
      .rsp_best_score   (rsp_best_score),
      .rsp_last_left    (rsp_last_left),
      .rsp_last_top     (rsp_last_top),
      .rsp_last_right   (rsp_last_right),
      .rsp_last_bottom  (rsp_last_bottom),
      .rsp_dropped      (rsp_dropped),
      .rsp_last         (rsp_last)
   );
endmodule
`default_nettype wire

// ===== rtl/igbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module igbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/igbt_ctrl.sv =====
// Controller: sequences loads, the end-of-frame matching pass and flushes.
`default_nettype none
module igbt_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [igbt_pkg::CMD_W-1:0]   req_command,
   output logic                              req_stall,
   input  wire igbt_pkg::dp_status_type      status,
   output igbt_pkg::ctrl_cmd_type            cmd
);
   import igbt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.done_kind = KIND_FRAME_DONE;
      req_stall     = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (command_type'(req_command))
                  CMD_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  CMD_END_FRAME: begin
                     cmd.start_frame = 1'b1;
                     if (!status.trk_empty) begin
                        state_in = S_T_RD;
                     end else if (!status.det_empty) begin
                        state_in = S_N_RD;
                     end else begin
                        state_in = S_F_DONE;
                     end
                  end
                  CMD_FLUSH: begin
                     cmd.clr_t = 1'b1;
                     state_in  = status.trk_empty ? S_L_DONE : S_L_RD;
                  end
                  CMD_NONE: begin
                  end
               endcase
            end
         end
         S_T_RD: state_in = S_T_LAT;
         S_T_LAT: begin
            cmd.latch_trk = 1'b1;
            cmd.clr_d     = 1'b1;
            state_in      = status.det_empty ? S_T_DEC : S_D_RD;
         end
         S_D_RD:    state_in = S_D_GEO;
         S_D_GEO:   state_in = S_D_MUL;
         S_D_MUL:   state_in = S_D_UNI;
         S_D_UNI:   state_in = S_D_CROSS;
         S_D_CROSS: state_in = S_D_CMP;
         S_D_CMP: begin
            cmd.cmp_en = 1'b1;
            if (status.d_last) begin
               state_in = S_T_DEC;
            end else begin
               cmd.inc_d = 1'b1;
               state_in  = S_D_RD;
            end
         end
         S_T_DEC: state_in = S_T_ACT;
         S_T_ACT: begin
            if (status.match_ok) begin
               state_in = S_B_RD;
            end else if (status.rec_ok) begin
               state_in = S_T_EMIT;
            end else begin
               state_in = S_T_NEXT;
            end
         end
         S_B_RD: begin
            cmd.best_rd = 1'b1;
            state_in    = S_B_WR;
         end
         S_B_WR: begin
            cmd.match_wr = 1'b1;
            state_in     = S_T_NEXT;
         end
         S_T_EMIT: begin
            if (status.out_free) begin
               cmd.emit_rec = 1'b1;
               state_in     = S_T_NEXT;
            end
         end
         S_T_NEXT: begin
            if (status.t_last) begin
               cmd.clr_d = 1'b1;
               state_in  = status.det_empty ? S_F_DONE : S_N_RD;
            end else begin
               cmd.inc_t = 1'b1;
               state_in  = S_T_RD;
            end
         end
         S_N_RD: state_in = S_N_WR;
         S_N_WR: begin
            cmd.new_wr = 1'b1;
            if (status.d_last) begin
               state_in = S_F_DONE;
            end else begin
               cmd.inc_d = 1'b1;
               state_in  = S_N_RD;
            end
         end
         S_F_DONE: begin
            if (status.out_free) begin
               cmd.emit_done = 1'b1;
               cmd.done_kind = KIND_FRAME_DONE;
               cmd.frame_end = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_L_RD: state_in = S_L_LAT;
         S_L_LAT: begin
            cmd.latch_trk = 1'b1;
            state_in      = S_L_CHK;
         end
         S_L_CHK: begin
            if (!status.flush_ok || status.out_free) begin
               cmd.emit_rec = status.flush_ok;
               if (status.t_last) begin
                  state_in = S_L_DONE;
               end else begin
                  cmd.inc_t = 1'b1;
                  state_in  = S_L_RD;
               end
            end
         end
         S_L_DONE: begin
            if (status.out_free) begin
               cmd.emit_done = 1'b1;
               cmd.done_kind = KIND_FLUSH_DONE;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/igbt_dp.sv =====
// Datapath: detection and track stores, IoU unit, counters and result register.
`default_nettype none
`include "iou_greedy_box_tracker_assert.svh"
module igbt_dp #(
   parameter int MAX_DETECTIONS = igbt_pkg::DEF_MAX_DETECTIONS,
   parameter int MAX_TRACKS     = igbt_pkg::DEF_MAX_TRACKS,
   parameter int COORD_BITS     = igbt_pkg::DEF_COORD_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire igbt_pkg::ctrl_cmd_type            cmd,
   output igbt_pkg::dp_status_type                status,
   input  wire logic [COORD_BITS-1:0]             req_box_left,
   input  wire logic [COORD_BITS-1:0]             req_box_top,
   input  wire logic [COORD_BITS-1:0]             req_box_right,
   input  wire logic [COORD_BITS-1:0]             req_box_bottom,
   input  wire logic [igbt_pkg::SCORE_W-1:0]      req_confidence,
   input  wire logic                              csr_wr,
   input  wire logic [igbt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [igbt_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [igbt_pkg::KIND_W-1:0]            rsp_kind,
   output logic [igbt_pkg::ID_W-1:0]              rsp_track_number,
   output logic [igbt_pkg::ID_W-1:0]              rsp_first_frame,
   output logic [igbt_pkg::LEN_W-1:0]             rsp_track_length,
   output logic [igbt_pkg::SCORE_W-1:0]           rsp_best_score,
   output logic [COORD_BITS-1:0]                  rsp_last_left,
   output logic [COORD_BITS-1:0]                  rsp_last_top,
   output logic [COORD_BITS-1:0]                  rsp_last_right,
   output logic [COORD_BITS-1:0]                  rsp_last_bottom,
   output logic [igbt_pkg::DROP_W-1:0]            rsp_dropped,
   output logic                                   rsp_last
);
   import igbt_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int DIDX_W = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
   localparam int TIDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int DCNT_W = $clog2(MAX_DETECTIONS + 1);
   localparam int TCNT_W = $clog2(MAX_TRACKS + 1);
   localparam int A_W    = 2 * C;
   localparam int U_W    = A_W + 1;
   localparam int P_W    = A_W + U_W;
   localparam int H_W    = U_W + SCORE_W;
   localparam int BOX_W  = 4 * C;
   localparam int DET_W  = BOX_W + SCORE_W;
   localparam int TRK_W  = BOX_W + SCORE_W + LEN_W + 2 * ID_W;

   function automatic logic [C-1:0] span(input logic [C-1:0] lo, input logic [C-1:0] hi);
      span = (hi > lo) ? (hi - lo) : '0;
   endfunction

   function automatic logic [C-1:0] max_c(input logic [C-1:0] a, input logic [C-1:0] b);
      max_c = (a > b) ? a : b;
   endfunction

   function automatic logic [C-1:0] min_c(input logic [C-1:0] a, input logic [C-1:0] b);
      min_c = (a < b) ? a : b;
   endfunction

   logic [SCORE_W-1:0]        score_high_ff, iou_min_ff;
   logic [LEN_W-1:0]          min_length_ff;
   logic [DCNT_W-1:0]         det_count_ff;
   logic [MAX_DETECTIONS-1:0] used_ff;
   logic [TCNT_W-1:0]         trk_count_ff, k_ff;
   logic [TIDX_W-1:0]         t_ff;
   logic [DIDX_W-1:0]         d_ff, best_ff;
   logic                      best_vld_ff;
   logic [ID_W-1:0]           next_ident_ff, frame_ff;
   logic [DROP_W-1:0]         drop_ff;
   logic                      rsp_valid_ff;

   logic [BOX_W-1:0]   trk_box_ff;
   logic [SCORE_W-1:0] trk_score_ff;
   logic [LEN_W-1:0]   trk_len_ff;
   logic [ID_W-1:0]    trk_ident_ff, trk_start_ff;
   logic [C-1:0]       tw_ff, th_ff, dw_ff, dh_ff, iw_ff, ih_ff;
   logic [A_W-1:0]     aa_ff, ab_ff, in_ff, in2_ff, bi_ff;
   logic [U_W-1:0]     un_ff, bu_ff;
   logic [P_W-1:0]     p1_ff, p2_ff;
   logic [H_W-1:0]     thr_ff;

   logic [KIND_W-1:0]  rsp_kind_ff;
   logic [ID_W-1:0]    rsp_track_number_ff, rsp_first_frame_ff;
   logic [LEN_W-1:0]   rsp_track_length_ff;
   logic [SCORE_W-1:0] rsp_best_score_ff;
   logic [BOX_W-1:0]   rsp_box_ff;
   logic [DROP_W-1:0]  rsp_dropped_ff;
   logic               rsp_last_ff;

   logic               det_we, trk_we, det_full, trk_full, new_open;
   logic [DIDX_W-1:0]  det_rd_addr;
   logic [DET_W-1:0]   det_wdata, det_rdata;
   logic [TRK_W-1:0]   trk_wdata, trk_rdata;
   logic [BOX_W-1:0]   det_box;
   logic [SCORE_W-1:0] det_score, match_score;
   logic [LEN_W-1:0]   match_len;
   logic [C-1:0]       tl, tt, tr, tb, dl, dt, dr, db;

   assign det_full    = (det_count_ff == DCNT_W'(MAX_DETECTIONS));
   assign trk_full    = (k_ff == TCNT_W'(MAX_TRACKS));
   assign det_we      = cmd.load && !det_full;
   assign det_wdata   = {req_confidence, req_box_bottom, req_box_right, req_box_top, req_box_left};
   assign det_rd_addr = cmd.best_rd ? best_ff : d_ff;
   assign det_box     = det_rdata[BOX_W-1:0];
   assign det_score   = det_rdata[DET_W-1:BOX_W];
   assign new_open    = cmd.new_wr && !used_ff[d_ff] && !trk_full;
   assign trk_we      = cmd.match_wr || new_open;
   assign match_score = (det_score > trk_score_ff) ? det_score : trk_score_ff;
   assign match_len   = (trk_len_ff < LEN_MAX) ? (trk_len_ff + LEN_W'(1)) : LEN_MAX;

   always_comb begin
      if (cmd.match_wr) begin
         trk_wdata = {trk_start_ff, trk_ident_ff, match_len, match_score, det_box};
      end else begin
         trk_wdata = {frame_ff, next_ident_ff, LEN_W'(1), det_score, det_box};
      end
   end

   igbt_ram #(.WIDTH(DET_W), .DEPTH(MAX_DETECTIONS)) u_det_ram (
      .clock   (clock),
      .wr_en   (det_we),
      .wr_addr (det_count_ff[DIDX_W-1:0]),
      .wr_data (det_wdata),
      .rd_addr (det_rd_addr),
      .rd_data (det_rdata)
   );

   igbt_ram #(.WIDTH(TRK_W), .DEPTH(MAX_TRACKS)) u_trk_ram (
      .clock   (clock),
      .wr_en   (trk_we),
      .wr_addr (k_ff[TIDX_W-1:0]),
      .wr_data (trk_wdata),
      .rd_addr (t_ff),
      .rd_data (trk_rdata)
   );

   assign tl = trk_box_ff[C-1:0];
   assign tt = trk_box_ff[2*C-1:C];
   assign tr = trk_box_ff[3*C-1:2*C];
   assign tb = trk_box_ff[4*C-1:3*C];
   assign dl = det_box[C-1:0];
   assign dt = det_box[2*C-1:C];
   assign dr = det_box[3*C-1:2*C];
   assign db = det_box[4*C-1:3*C];

   always_ff @(posedge clock) begin
      if (reset) begin
         score_high_ff <= SCORE_HIGH_RST;
         iou_min_ff    <= IOU_MIN_RST;
         min_length_ff <= MIN_LENGTH_RST;
         det_count_ff  <= '0;
         used_ff       <= '0;
         trk_count_ff  <= '0;
         k_ff          <= '0;
         t_ff          <= '0;
         d_ff          <= '0;
         best_ff       <= '0;
         best_vld_ff   <= 1'b0;
         next_ident_ff <= '0;
         frame_ff      <= '0;
         drop_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_index_type'(csr_index))
               CSR_SCORE_HIGH: score_high_ff <= csr_data;
               CSR_IOU_MIN:    iou_min_ff    <= csr_data;
               CSR_MIN_LENGTH: min_length_ff <= csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            if (det_full) begin
               drop_ff[0] <= 1'b1;
            end else begin
               det_count_ff <= det_count_ff + DCNT_W'(1);
            end
         end
         if (cmd.start_frame) begin
            k_ff <= '0;
            t_ff <= '0;
            d_ff <= '0;
         end
         if (cmd.clr_t) begin
            t_ff <= '0;
         end
         if (cmd.inc_t) begin
            t_ff <= t_ff + TIDX_W'(1);
         end
         if (cmd.clr_d) begin
            d_ff <= '0;
         end
         if (cmd.inc_d) begin
            d_ff <= d_ff + DIDX_W'(1);
         end
         if (cmd.latch_trk) begin
            best_vld_ff <= 1'b0;
         end
         if (cmd.cmp_en && !used_ff[d_ff] && (p1_ff > p2_ff)) begin
            best_vld_ff <= 1'b1;
            best_ff     <= d_ff;
         end
         if (cmd.match_wr) begin
            used_ff[best_ff] <= 1'b1;
            k_ff             <= k_ff + TCNT_W'(1);
         end
         if (new_open) begin
            k_ff          <= k_ff + TCNT_W'(1);
            next_ident_ff <= next_ident_ff + ID_W'(1);
         end
         if (cmd.new_wr && !used_ff[d_ff] && trk_full) begin
            drop_ff[1] <= 1'b1;
         end
         if (cmd.frame_end) begin
            trk_count_ff <= k_ff;
            frame_ff     <= frame_ff + ID_W'(1);
            drop_ff      <= '0;
            det_count_ff <= '0;
            used_ff      <= '0;
         end
         if (cmd.emit_rec || cmd.emit_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_trk) begin
         trk_box_ff   <= trk_rdata[BOX_W-1:0];
         trk_score_ff <= trk_rdata[BOX_W+SCORE_W-1:BOX_W];
         trk_len_ff   <= trk_rdata[BOX_W+SCORE_W+LEN_W-1:BOX_W+SCORE_W];
         trk_ident_ff <= trk_rdata[BOX_W+SCORE_W+LEN_W+ID_W-1:BOX_W+SCORE_W+LEN_W];
         trk_start_ff <= trk_rdata[TRK_W-1:BOX_W+SCORE_W+LEN_W+ID_W];
         bi_ff        <= '0;
         bu_ff        <= U_W'(1);
      end else if (cmd.cmp_en && !used_ff[d_ff] && (p1_ff > p2_ff)) begin
         bi_ff <= in2_ff;
         bu_ff <= un_ff;
      end
      tw_ff  <= span(tl, tr);
      th_ff  <= span(tt, tb);
      dw_ff  <= span(dl, dr);
      dh_ff  <= span(dt, db);
      iw_ff  <= span(max_c(tl, dl), min_c(tr, dr));
      ih_ff  <= span(max_c(tt, dt), min_c(tb, db));
      aa_ff  <= A_W'(tw_ff) * A_W'(th_ff);
      ab_ff  <= A_W'(dw_ff) * A_W'(dh_ff);
      in_ff  <= A_W'(iw_ff) * A_W'(ih_ff);
      un_ff  <= U_W'(aa_ff) + U_W'(ab_ff) - U_W'(in_ff);
      in2_ff <= in_ff;
      p1_ff  <= P_W'(in2_ff) * P_W'(bu_ff);
      p2_ff  <= P_W'(bi_ff) * P_W'(un_ff);
      thr_ff <= H_W'(iou_min_ff) * H_W'(bu_ff);
      if (cmd.emit_rec) begin
         rsp_kind_ff         <= KIND_TRACK;
         rsp_track_number_ff <= trk_ident_ff;
         rsp_first_frame_ff  <= trk_start_ff;
         rsp_track_length_ff <= trk_len_ff;
         rsp_best_score_ff   <= trk_score_ff;
         rsp_box_ff          <= trk_box_ff;
         rsp_dropped_ff      <= '0;
         rsp_last_ff         <= 1'b0;
      end else if (cmd.emit_done) begin
         rsp_kind_ff         <= cmd.done_kind;
         rsp_track_number_ff <= '0;
         rsp_first_frame_ff  <= '0;
         rsp_track_length_ff <= '0;
         rsp_best_score_ff   <= '0;
         rsp_box_ff          <= '0;
         rsp_dropped_ff      <= drop_ff;
         rsp_last_ff         <= 1'b1;
      end
   end

   assign status.trk_empty = (trk_count_ff == '0);
   assign status.det_empty = (det_count_ff == '0);
   assign status.t_last    = ((TCNT_W'(t_ff) + TCNT_W'(1)) == trk_count_ff);
   assign status.d_last    = ((DCNT_W'(d_ff) + DCNT_W'(1)) == det_count_ff);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.match_ok  = best_vld_ff && ({1'b0, bi_ff, 16'b0} > thr_ff);
   assign status.rec_ok    = (trk_score_ff >= score_high_ff) && (trk_len_ff >= min_length_ff);
   assign status.flush_ok  = (trk_score_ff >= score_high_ff) && (trk_len_ff > min_length_ff);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_track_number = rsp_track_number_ff;
   assign rsp_first_frame  = rsp_first_frame_ff;
   assign rsp_track_length = rsp_track_length_ff;
   assign rsp_best_score   = rsp_best_score_ff;
   assign rsp_last_left    = rsp_box_ff[C-1:0];
   assign rsp_last_top     = rsp_box_ff[2*C-1:C];
   assign rsp_last_right   = rsp_box_ff[3*C-1:2*C];
   assign rsp_last_bottom  = rsp_box_ff[4*C-1:3*C];
   assign rsp_dropped      = rsp_dropped_ff;
   assign rsp_last         = rsp_last_ff;

   `IGBT_ASSERT_IMPL(a_wr_behind_rd, clock, reset, cmd.match_wr, k_ff <= TCNT_W'(t_ff))
   `IGBT_ASSERT_IMPL(a_emit_free, clock, reset, cmd.emit_rec || cmd.emit_done,
                     !rsp_valid_ff || !rsp_stall)
   `IGBT_ASSERT_NEXT(a_det_drop, clock, reset, cmd.load && det_full, drop_ff[0])
endmodule
`default_nettype wire
